// ===== design/u8gsd_pkg.sv =====
// Package for the UTF-8 glyph stream decoder.
// Holds the byte-class masks, glyph geometry constants and the queue entry types.
// No dependencies.
package u8gsd_pkg;

	// Byte-class masks and tags for lead and continuation bytes.
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_BITS = 8'h07;

	// Glyph geometry.
	localparam logic [15:0] GLYPH_ADVANCE = 16'd12;
	localparam logic [15:0] TOP_OFFSET    = 16'd12;

	// Configuration register indexes.
	localparam logic CFG_FG = 1'b0;
	localparam logic CFG_BG = 1'b1;

	// Glyph kinds.
	localparam logic KIND_CHAR        = 1'b0;
	localparam logic KIND_PLACEHOLDER = 1'b1;

	// One queue entry holds every glyph that one input byte produced.
	// The second glyph, when present, is always a plain character.
	typedef struct packed {
		logic        two;
		logic [20:0] cp0;
		logic [6:0]  cp1;
		logic [15:0] x0;
		logic [15:0] top;
	} glyph_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== design/u8gsd_front.sv =====
// Front part of the UTF-8 glyph stream decoder: accepts bytes, tracks the
// decode state and pen, and writes one entry per productive byte to the queue.
// Depends on u8gsd_pkg.
module u8gsd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  logic [7:0]              text_byte,
	input  logic                    string_start,
	input  logic signed [15:0]      start_x,
	input  logic signed [15:0]      base_y,
	input  u8gsd_pkg::queue_status_t q_status,
	output logic                    q_push,
	output u8gsd_pkg::glyph_entry_t q_entry
);

	logic [1:0]  br_q;
	logic [20:0] acc_q;
	logic [7:0]  held_q;
	logic [15:0] pen_q;
	logic [15:0] top_q;
	logic        act_q;

	logic [1:0]  eff_br;
	logic [20:0] eff_acc;
	logic [7:0]  eff_held;
	logic [15:0] eff_pen;
	logic [15:0] eff_top;
	logic        eff_act;

	logic [1:0]  br_n;
	logic [20:0] acc_n;
	logic [7:0]  held_n;
	logic [15:0] pen_n;
	logic        act_n;

	logic        a_v;
	logic [20:0] a_cp;
	logic        b_v;
	logic [6:0]  b_cp;
	logic        cont_taken;
	logic        accept;

	// The queue being full is the only reason to hold off a byte.
	assign byte_stall = q_status.full;
	assign accept     = byte_valid && !byte_stall;

	// Decode one byte against the current (or freshly started) state.
	always_comb begin
		eff_br   = string_start ? 2'd0 : br_q;
		eff_acc  = string_start ? 21'd0 : acc_q;
		eff_held = string_start ? 8'd0 : held_q;
		eff_pen  = string_start ? $unsigned(start_x) : pen_q;
		eff_top  = string_start ? ($unsigned(base_y) - u8gsd_pkg::TOP_OFFSET) : top_q;
		eff_act  = string_start || act_q;

		br_n       = eff_br;
		acc_n      = eff_acc;
		held_n     = eff_held;
		act_n      = eff_act;
		a_v        = 1'b0;
		a_cp       = '0;
		b_v        = 1'b0;
		b_cp       = '0;
		cont_taken = 1'b0;

		// A pending sequence either takes a continuation byte or is flushed.
		if (eff_br != 2'd0) begin
			if ((text_byte & u8gsd_pkg::CONT_MASK) == u8gsd_pkg::CONT_TAG) begin
				acc_n      = {eff_acc[14:0], text_byte[5:0]};
				br_n       = eff_br - 2'd1;
				cont_taken = 1'b1;
				if (eff_br == 2'd1) begin
					a_v  = 1'b1;
					a_cp = {eff_acc[14:0], text_byte[5:0]};
				end
			end else begin
				a_v  = 1'b1;
				a_cp = {13'd0, eff_held};
				br_n = 2'd0;
			end
		end

		// Otherwise the byte is taken as a lead.
		if (!cont_taken) begin
			if (text_byte == 8'd0) begin
				act_n = 1'b0;
			end else if (!text_byte[7]) begin
				b_v  = 1'b1;
				b_cp = text_byte[6:0];
			end else if ((text_byte & u8gsd_pkg::LEAD2_MASK) == u8gsd_pkg::LEAD2_TAG) begin
				acc_n  = {13'd0, text_byte & u8gsd_pkg::LEAD2_BITS};
				br_n   = 2'd1;
				held_n = text_byte;
			end else if ((text_byte & u8gsd_pkg::LEAD3_MASK) == u8gsd_pkg::LEAD3_TAG) begin
				acc_n  = {13'd0, text_byte & u8gsd_pkg::LEAD3_BITS};
				br_n   = 2'd2;
				held_n = text_byte;
			end else if ((text_byte & u8gsd_pkg::LEAD4_MASK) == u8gsd_pkg::LEAD4_TAG) begin
				acc_n  = {13'd0, text_byte & u8gsd_pkg::LEAD4_BITS};
				br_n   = 2'd3;
				held_n = text_byte;
			end
		end

		// Pen advances once for each glyph this byte produced.
		if (a_v && b_v) begin
			pen_n = eff_pen + u8gsd_pkg::GLYPH_ADVANCE + u8gsd_pkg::GLYPH_ADVANCE;
		end else if (a_v || b_v) begin
			pen_n = eff_pen + u8gsd_pkg::GLYPH_ADVANCE;
		end else begin
			pen_n = eff_pen;
		end
	end

	// Queue entry for this byte.
	always_comb begin
		q_entry.two = a_v && b_v;
		q_entry.cp0 = a_v ? a_cp : {14'd0, b_cp};
		q_entry.cp1 = b_cp;
		q_entry.x0  = eff_pen;
		q_entry.top = eff_top;
	end

	assign q_push = accept && eff_act && (a_v || b_v);

	// Decoder state; a byte seen while idle without a start changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q   <= 2'd0;
			acc_q  <= 21'd0;
			held_q <= 8'd0;
			pen_q  <= 16'd0;
			top_q  <= 16'd0;
			act_q  <= 1'b0;
		end else if (accept && eff_act) begin
			br_q   <= br_n;
			acc_q  <= acc_n;
			held_q <= held_n;
			pen_q  <= pen_n;
			top_q  <= eff_top;
			act_q  <= act_n;
		end
	end

endmodule

// ===== design/u8gsd_queue.sv =====
// Short queue of glyph entries between the front and back parts of the decoder.
// Depends on u8gsd_pkg.
module u8gsd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  u8gsd_pkg::glyph_entry_t  wr_entry,
	input  logic                     pop,
	output u8gsd_pkg::glyph_entry_t  head,
	output u8gsd_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	u8gsd_pkg::glyph_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/u8gsd_back.sv =====
// Back part of the UTF-8 glyph stream decoder: holds the colour registers,
// splits queue entries into glyph beats and drives the output register.
// Depends on u8gsd_pkg.
module u8gsd_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [15:0]              cfg_data,
	input  u8gsd_pkg::glyph_entry_t  head,
	input  u8gsd_pkg::queue_status_t q_status,
	output logic                     q_pop,
	output logic                     glyph_valid,
	input  logic                     glyph_stall,
	output logic                     glyph_kind,
	output logic [20:0]              code_point,
	output logic signed [15:0]       glyph_x,
	output logic signed [15:0]       glyph_top,
	output logic [15:0]              fg_out,
	output logic [15:0]              bg_out,
	output logic                     last_in_run
);

	logic [15:0] fg_q;
	logic [15:0] bg_q;
	logic        phase_q;
	logic        valid_q;
	logic        kind_q;
	logic [20:0] cp_q;
	logic [15:0] x_q;
	logic [15:0] top_q;
	logic [15:0] fgo_q;
	logic [15:0] bgo_q;
	logic        last_q;

	logic        load;
	logic        beat_kind;
	logic [20:0] beat_cp;
	logic [15:0] beat_x;
	logic        beat_last;

	assign cfg_ready = 1'b1;

	// Colour registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 16'hFFFF;
			bg_q <= 16'h0000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				u8gsd_pkg::CFG_FG: fg_q <= cfg_data;
				u8gsd_pkg::CFG_BG: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pick the beat for the current phase of the head entry.
	always_comb begin
		if (phase_q) begin
			beat_kind = u8gsd_pkg::KIND_CHAR;
			beat_cp   = {14'd0, head.cp1};
			beat_x    = head.x0 + u8gsd_pkg::GLYPH_ADVANCE;
			beat_last = 1'b1;
		end else begin
			beat_kind = (head.cp0[20:7] != 14'd0) ? u8gsd_pkg::KIND_PLACEHOLDER
			                                      : u8gsd_pkg::KIND_CHAR;
			beat_cp   = head.cp0;
			beat_x    = head.x0;
			beat_last = !head.two;
		end
	end

	assign load  = !valid_q || !glyph_stall;
	assign q_pop = load && !q_status.empty && beat_last;

	// Output register control and beat phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_status.empty;
			if (!q_status.empty) begin
				phase_q <= !beat_last;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load && !q_status.empty) begin
			kind_q <= beat_kind;
			cp_q   <= beat_cp;
			x_q    <= beat_x;
			top_q  <= head.top;
			fgo_q  <= fg_q;
			bgo_q  <= (beat_kind == u8gsd_pkg::KIND_PLACEHOLDER) ? 16'd0 : bg_q;
			last_q <= beat_last;
		end
	end

	assign glyph_valid = valid_q;
	assign glyph_kind  = kind_q;
	assign code_point  = cp_q;
	assign glyph_x     = $signed(x_q);
	assign glyph_top   = $signed(top_q);
	assign fg_out      = fgo_q;
	assign bg_out      = bgo_q;
	assign last_in_run = last_q;

endmodule

// ===== design/utf8_glyph_stream_decoder_top.sv =====
// UTF-8 glyph stream decoder, top level. Takes one text byte per cycle while byte_stall is low.
// A glyph beat is written into the entry queue and then into the output register after its byte is taken.
// Throughput: one byte per cycle; a byte that yields two glyphs uses an output beat
// for each, and the entry queue absorbs that so input stalls only when it fills.
// Reset clears the decode state and pen, leaves the block idle, and sets the
// foreground colour to 0xFFFF and the background colour to 0.
module utf8_glyph_stream_decoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         text_byte,
	input  logic               string_start,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] base_y,
	output logic               glyph_valid,
	input  logic               glyph_stall,
	output logic               glyph_kind,
	output logic [20:0]        code_point,
	output logic signed [15:0] glyph_x,
	output logic signed [15:0] glyph_top,
	output logic [15:0]        fg_out,
	output logic [15:0]        bg_out,
	output logic               last_in_run,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	u8gsd_pkg::glyph_entry_t  wr_entry;
	u8gsd_pkg::glyph_entry_t  head;
	u8gsd_pkg::queue_status_t q_status;
	logic                     q_push;
	logic                     q_pop;

	// Front part: byte acceptance and decoding.
	u8gsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.text_byte    (text_byte),
		.string_start (string_start),
		.start_x      (start_x),
		.base_y       (base_y),
		.q_status     (q_status),
		.q_push       (q_push),
		.q_entry      (wr_entry)
	);

	// Entry queue between the two parts.
	u8gsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.head     (head),
		.status   (q_status)
	);

	// Back part: glyph beats and colours.
	u8gsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.head        (head),
		.q_status    (q_status),
		.q_pop       (q_pop),
		.glyph_valid (glyph_valid),
		.glyph_stall (glyph_stall),
		.glyph_kind  (glyph_kind),
		.code_point  (code_point),
		.glyph_x     (glyph_x),
		.glyph_top   (glyph_top),
		.fg_out      (fg_out),
		.bg_out      (bg_out),
		.last_in_run (last_in_run)
	);

	// The front never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("queue written while full");

	// The back only pops an entry that is present.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("queue popped while empty");

	// After the first beat of a two-glyph byte, its second beat follows at once.
	a_second_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(glyph_valid && !glyph_stall && !last_in_run) |=> (glyph_valid && last_in_run))
		else $error("second glyph beat missing");

	// A character beat never carries a code point of 128 or above.
	a_kind_match: assert property (@(posedge clk) disable iff (!arst_n)
		(glyph_valid && (glyph_kind == u8gsd_pkg::KIND_CHAR)) |-> (code_point[20:7] == 14'd0))
		else $error("character glyph with wide code point");

endmodule
